### rtl/core/ira_pkg.sv
// Shared types, constants and helpers for the radix-to-ASCII converter.
`default_nettype none

package ira_pkg;

   // Operand and digit widths fixed by the item format
   localparam int VALUE_W  = 32;
   localparam int BASE_W   = 6;
   localparam int DIGIT_W  = 6;
   localparam int SLOTS    = 32;
   localparam int SLOT_W   = 5;
   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 2;
   // Width that holds any field length or position up to 64
   localparam int CMP_W    = 7;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_BASE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

   // Base limits
   localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
   localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

   // Fixed characters
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

   // Kind of character at one field position
   localparam logic [1:0] KIND_NUL   = 2'd0;
   localparam logic [1:0] KIND_MINUS = 2'd1;
   localparam logic [1:0] KIND_DIGIT = 2'd2;
   localparam logic [1:0] KIND_SPACE = 2'd3;

   // Divider result seen by the sequencer
   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] quot;
      logic [DIGIT_W-1:0] rem;
   } div_result_type;

   // Map a digit value 0..35 to 0-9a-z
   function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = CHAR_W'(d);
      if (d < 6'd10) begin
         glyph = 8'h30 + d_ext;
      end else begin
         glyph = 8'h57 + d_ext;
      end
   endfunction

endpackage

`default_nettype wire

### rtl/core/ira_div.sv
// Iterative restoring divider: 32-bit dividend by 6-bit base, one quotient bit per cycle.
`default_nettype none

module ira_div
   import ira_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [VALUE_W-1:0] dividend,
   input  wire logic [BASE_W-1:0]  divisor,
   output div_result_type          res
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [SLOT_W-1:0]  cnt_ff, cnt_in;
   logic [VALUE_W-1:0] quot_ff, quot_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [BASE_W-1:0]  dvs_ff, dvs_in;
   logic [DIGIT_W:0]   trial;
   logic [DIGIT_W:0]   diff;
   logic               ge;

   // Shift one dividend bit into the partial remainder and try the subtract
   always_comb begin
      trial = {rem_ff, quot_ff[VALUE_W-1]};
      ge    = trial >= {1'b0, dvs_ff};
      diff  = trial - {1'b0, dvs_ff};
   end

   // Load on start, step while busy
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = SLOT_W'(VALUE_W - 1);
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[VALUE_W-2:0], ge};
         rem_in  = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign res.done = done_ff;
   assign res.quot = quot_ff;
   assign res.rem  = rem_ff;

endmodule

`default_nettype wire

### rtl/core/int_to_radix_ascii.sv
// Top level: signed integer to fixed-width ASCII field in bases 2 to 36.
//
//   channel | dir | ports                                       | transfer when
//   --------+-----+---------------------------------------------+-----------------------
//   req     | in  | req_value[31:0] req_base[5:0]               | req_valid & !req_stall
//   rsp     | out | rsp_character[7:0] rsp_last_of_run rsp_status | rsp_valid & !rsp_stall
//   csr     | in  | csr_wr_data[5:0] (buffer_length)            | csr_wr_en
//
// Flow: one item per conversion; req_stall stays high until its last result transfers.
// Digit loop: one pass of 32 shift steps per digit in the shared divider, 1 to 32 digits.
// Then the fit check, and per character a digit store read, then show.
// A bad base gives its error result in the cycle after the accept; a long number after the digits.
// Reset (synchronous): sequencer idle, buffer_length 12; the digit store is not cleared.
// A stalled result holds its payload until the downstream side takes it.
`default_nettype none

module int_to_radix_ascii
   import ira_pkg::*;
#(
   parameter int MAX_FIELD_LENGTH = 40
)(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic [BASE_W-1:0]   req_base,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [CHAR_W-1:0]   rsp_character,
   output      logic                rsp_last_of_run,
   output      logic [STATUS_W-1:0] rsp_status,
   input  wire logic                csr_wr_en,
   input  wire logic [BASE_W-1:0]   csr_wr_data
);

   localparam int LEN_W = $clog2(MAX_FIELD_LENGTH + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_FETCH = 3'd3;
   localparam logic [2:0] S_SHOW  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [BASE_W-1:0]   csr_len_ff, csr_len_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic                sign_ff, sign_in;
   logic [DIGIT_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]    pos_ff, pos_in;
   logic [1:0]          kind_ff, kind_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [DIGIT_W-1:0]  rd_data_ff;
   logic [DIGIT_W-1:0]  digit_mem [SLOTS];

   logic                req_xfer, rsp_xfer;
   logic                base_ok;
   logic [VALUE_W-1:0]  raw;
   logic [VALUE_W-1:0]  mag;
   logic [CMP_W-1:0]    len_sat;
   logic [CMP_W-1:0]    len_m1;
   logic [CMP_W-1:0]    pos_ext;
   logic [CMP_W-1:0]    places;
   logic [CMP_W-1:0]    digit_idx;
   logic                is_last;
   logic                div_start;
   logic [VALUE_W-1:0]  div_dividend;
   logic [BASE_W-1:0]   div_divisor;
   logic                mem_we;
   logic                mem_re;
   div_result_type      div_res;

   // Shared divider produces one digit per pass
   ira_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .res      (div_res)
   );

   // Handshake and input decode
   always_comb begin
      req_stall = state_ff != S_IDLE;
      rsp_valid = state_ff == S_SHOW;
      req_xfer  = req_valid && !req_stall;
      rsp_xfer  = rsp_valid && !rsp_stall;
      base_ok   = (req_base >= BASE_MIN) && (req_base <= BASE_MAX);
      raw       = $unsigned(req_value);
      mag       = raw[VALUE_W-1] ? (~raw + 32'd1) : raw;
   end

   // Saturate the field length at use
   always_comb begin
      len_sat = CMP_W'(csr_len_ff);
      if (len_sat < CMP_W'(2)) begin
         len_sat = CMP_W'(2);
      end else if (len_sat > CMP_W'(MAX_FIELD_LENGTH)) begin
         len_sat = CMP_W'(MAX_FIELD_LENGTH);
      end
   end

   // Position arithmetic
   always_comb begin
      len_m1    = CMP_W'(len_ff) - 1'b1;
      pos_ext   = CMP_W'(pos_ff);
      places    = CMP_W'(sign_ff) + CMP_W'(count_ff);
      digit_idx = places - 1'b1 - pos_ext;
      is_last   = pos_ext == len_m1;
      if (is_last) begin
         kind_in = KIND_NUL;
      end else if (sign_ff && (pos_ext == '0)) begin
         kind_in = KIND_MINUS;
      end else if (pos_ext < places) begin
         kind_in = KIND_DIGIT;
      end else begin
         kind_in = KIND_SPACE;
      end
   end

   // Start the divider on accept of a valid base and again while the quotient is nonzero
   always_comb begin
      div_start    = 1'b0;
      div_dividend = mag;
      div_divisor  = base_ff;
      if (req_xfer && base_ok) begin
         div_start   = 1'b1;
         div_divisor = req_base;
      end else if ((state_ff == S_DIV) && div_res.done && (div_res.quot != '0)) begin
         div_start    = 1'b1;
         div_dividend = div_res.quot;
      end
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      csr_len_in = csr_wr_en ? csr_wr_data : csr_len_ff;
      len_in     = len_ff;
      base_in    = base_ff;
      sign_in    = sign_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      status_in  = status_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               len_in   = LEN_W'(len_sat);
               base_in  = req_base;
               sign_in  = raw[VALUE_W-1];
               count_in = '0;
               pos_in   = '0;
               if (base_ok) begin
                  status_in = STATUS_OK;
                  state_in  = S_DIV;
               end else begin
                  status_in = STATUS_BAD_BASE;
                  state_in  = S_SHOW;
               end
            end
         end
         S_DIV: begin
            if (div_res.done) begin
               mem_we   = count_ff < DIGIT_W'(SLOTS);
               count_in = count_ff + 1'b1;
               if (div_res.quot == '0) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (places > len_m1) begin
               status_in = STATUS_TOO_LONG;
            end
            state_in = (places > len_m1) ? S_SHOW : S_FETCH;
         end
         S_FETCH: begin
            mem_re   = 1'b1;
            state_in = S_SHOW;
         end
         S_SHOW: begin
            if (rsp_xfer) begin
               if ((status_ff != STATUS_OK) || is_last) begin
                  state_in = S_IDLE;
               end else begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         csr_len_ff <= 6'd12;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         csr_len_ff <= csr_len_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      base_ff   <= base_in;
      sign_ff   <= sign_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      if (state_ff == S_FETCH) begin
         kind_ff <= kind_in;
      end
   end

   // Digit store: write one digit per divider pass, registered read while fetching
   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[count_ff[SLOT_W-1:0]] <= div_res.rem;
      end
      if (mem_re) begin
         rd_data_ff <= digit_mem[digit_idx[SLOT_W-1:0]];
      end
   end

   // Form the outgoing character
   always_comb begin
      rsp_status      = status_ff;
      rsp_last_of_run = (status_ff != STATUS_OK) || is_last;
      if (status_ff != STATUS_OK) begin
         rsp_character = CH_NUL;
      end else begin
         unique case (kind_ff)
            KIND_NUL:   rsp_character = CH_NUL;
            KIND_MINUS: rsp_character = CH_MINUS;
            KIND_DIGIT: rsp_character = glyph(rd_data_ff);
            KIND_SPACE: rsp_character = CH_SPACE;
            default:    rsp_character = CH_NUL;
         endcase
      end
   end

   // Never take a new item while a result is on offer
   a_no_accept_while_showing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("item accepted while a result is pending");

   // Digit count stays within the store
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DIGIT_W'(SLOTS))
      else $error("digit count beyond store depth");

   // Error results are single and final
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |-> (rsp_last_of_run && rsp_character == CH_NUL))
      else $error("error result not marked last");

   // After the final transfer of a run the block is ready again
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_of_run) |=> !req_stall)
      else $error("not ready after the last transfer");

endmodule

`default_nettype wire
